### rtl/lru_pkg.sv
// shared constants and types for the lru page replacement stack
package lru_pkg;

  localparam int MAX_FRAME_SLOTS_DEF = 16;
  localparam int PAGE_W              = 16;
  localparam int FAULT_W             = 32;
  localparam int CFG_DATA_W          = 32;
  localparam int CFG_ADDR_W          = 3;
  localparam int CFG_FRAMES_W        = 5;
  localparam int FRAMES_RESET        = 4;

  // register indexes
  localparam logic [CFG_ADDR_W-3:0] REG_FRAMES = '0;

  // per-cell control
  typedef struct packed {
    logic take;    // a reference is transferred this cycle
    logic flush;   // empty the frame
    logic hit;     // the reference matched somewhere in the row
    logic is_top;  // this cell is the most recent position
    logic active;  // this cell lies below frames_in_use
  } lru_cell_ctl_t;

endpackage

### rtl/lru_if.sv
// reference and result channel interfaces
interface lru_req_if import lru_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page;
  logic              end_of_run;

  modport source (output valid, page, end_of_run, input ready);
  modport sink   (input valid, page, end_of_run, output ready);
endinterface

interface lru_rsp_if import lru_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               fault;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [FAULT_W-1:0] fault_total;

  modport source (output valid, fault, evicted_valid, evicted_page, fault_total,
                  input ready);
  modport sink   (input valid, fault, evicted_valid, evicted_page, fault_total,
                  output ready);
endinterface

### rtl/lru_cell.sv
// one recency stack position: compare, hit chain and shift from the upper neighbor
module lru_cell import lru_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  lru_cell_ctl_t     ctl,
  input  logic [PAGE_W-1:0] key,
  input  logic              hit_seen_in,
  output logic              hit_seen_out,
  input  logic [PAGE_W-1:0] nbr_page,
  input  logic              nbr_valid,
  output logic [PAGE_W-1:0] page_q,
  output logic              valid_q,
  output logic              match
);

  logic [PAGE_W-1:0] page_r, page_nxt;
  logic              valid_r, valid_nxt;
  logic              shift;

  assign match        = ctl.active & valid_r & (page_r == key);
  assign hit_seen_out = hit_seen_in | match;
  // on a miss everything moves down; on a hit only cells at or above the hit
  assign shift        = ~ctl.hit | hit_seen_out;

  always_comb begin
    page_nxt  = page_r;
    valid_nxt = valid_r;
    if (ctl.take) begin
      if (ctl.is_top) begin
        page_nxt  = key;
        valid_nxt = 1'b1;
      end else if (ctl.active && shift) begin
        page_nxt  = nbr_page;
        valid_nxt = nbr_valid;
      end
    end
    if (ctl.flush) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign page_q  = page_r;
  assign valid_q = valid_r;

endmodule

### rtl/lru_page_replacement_stack_unit.sv
// top level: lru recency stack built as a row of cells, result register and apb config
// The block takes page references and returns one result per reference,
// registered, in the cycle after the transfer. The recency stack is a row of
// MAX_FRAME_SLOTS cells; position 0 is the least recently used. Each cell compares
// its page with the reference in parallel, a hit flag ripples up the row, and in the
// same cycle each cell at or above the hit (every cell on a miss) takes the page of
// its upper neighbor while the top cell (frames_in_use - 1) takes the reference.
// That compare and shift across the row sets the rate: one reference per cycle while
// the result side takes results, the result register freeing up as soon as it is taken.
// frames_in_use sits at byte address 0; writing its low CFG_FRAMES_W bits (0 acts as 1,
// over MAX_FRAME_SLOTS saturate) empties the frames and clears the fault total, as does
// a reference flagged end_of_run once its result has been formed.
module lru_page_replacement_stack_unit import lru_pkg::*; #(
  parameter int MAX_FRAME_SLOTS = MAX_FRAME_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lru_req_if.sink               in_ch,
  lru_rsp_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int FW    = $clog2(MAX_FRAME_SLOTS + 1);
  localparam int CMP_W = (FW > CFG_FRAMES_W) ? FW : CFG_FRAMES_W;
  localparam logic [FW-1:0] FRAMES_INIT =
    FW'((FRAMES_RESET > MAX_FRAME_SLOTS) ? MAX_FRAME_SLOTS : FRAMES_RESET);
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_FRAME_SLOTS);

  // config port
  logic              cfg_wr;
  logic              cfg_sel_frames;
  logic [FW-1:0]     frames_r, frames_nxt;
  logic [CMP_W-1:0]  wr_frames;

  assign cfg_pready     = 1'b1;
  assign cfg_sel_frames = (cfg_paddr[CFG_ADDR_W-1:2] == REG_FRAMES);
  assign cfg_wr         = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign wr_frames      = CMP_W'(cfg_pwdata[CFG_FRAMES_W-1:0]);
  assign cfg_prdata     = cfg_sel_frames ? CFG_DATA_W'(frames_r) : '0;

  // clamp the written frame count into 1..MAX_FRAME_SLOTS
  always_comb begin
    frames_nxt = frames_r;
    if (cfg_wr && cfg_sel_frames) begin
      if (wr_frames == '0) begin
        frames_nxt = FW'(1);
      end else if (wr_frames > MAX_CMP) begin
        frames_nxt = FW'(MAX_FRAME_SLOTS);
      end else begin
        frames_nxt = wr_frames[FW-1:0];
      end
    end
  end

  // handshake: the result register parts the two sides
  logic take;
  logic out_valid_r;

  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign take        = in_ch.valid & in_ch.ready;

  // cell row
  logic [FW-1:0]           top_idx;
  logic [MAX_FRAME_SLOTS:0] hit_chain;
  logic [MAX_FRAME_SLOTS-1:0] match_vec;
  logic [MAX_FRAME_SLOTS-1:0] valid_vec;
  logic [PAGE_W-1:0]       page_vec [MAX_FRAME_SLOTS];
  logic                    hit;
  logic                    flush;

  assign top_idx      = frames_r - FW'(1);
  assign hit_chain[0] = 1'b0;
  assign hit          = hit_chain[MAX_FRAME_SLOTS];
  assign flush        = (cfg_wr & cfg_sel_frames) | (take & in_ch.end_of_run);

  for (genvar k = 0; k < MAX_FRAME_SLOTS; k++) begin : g_cell
    lru_cell_ctl_t     ctl;
    logic [PAGE_W-1:0] nbr_page;
    logic              nbr_valid;

    assign ctl.take   = take;
    assign ctl.flush  = flush;
    assign ctl.hit    = hit;
    assign ctl.is_top = (top_idx == FW'(k));
    assign ctl.active = (FW'(k) < frames_r);

    if (k == MAX_FRAME_SLOTS - 1) begin : g_last
      assign nbr_page  = '0;
      assign nbr_valid = 1'b0;
    end else begin : g_mid
      assign nbr_page  = page_vec[k+1];
      assign nbr_valid = valid_vec[k+1];
    end

    lru_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .key          (in_ch.page),
      .hit_seen_in  (hit_chain[k]),
      .hit_seen_out (hit_chain[k+1]),
      .nbr_page     (nbr_page),
      .nbr_valid    (nbr_valid),
      .page_q       (page_vec[k]),
      .valid_q      (valid_vec[k]),
      .match        (match_vec[k])
    );
  end

  // saturating fault total
  logic [FAULT_W-1:0] fault_cnt_r, fault_cnt_nxt, fault_cnt_upd;

  assign fault_cnt_upd = (!hit && (fault_cnt_r != '1)) ? fault_cnt_r + FAULT_W'(1)
                                                       : fault_cnt_r;

  always_comb begin
    fault_cnt_nxt = fault_cnt_r;
    if (take) begin
      fault_cnt_nxt = fault_cnt_upd;
    end
    if (flush) begin
      fault_cnt_nxt = '0;
    end
  end

  // result register
  logic               fault_r;
  logic               ev_valid_r;
  logic [PAGE_W-1:0]  ev_page_r;
  logic [FAULT_W-1:0] total_r;
  logic               ev_valid;

  // the oldest entry leaves only on a miss
  assign ev_valid = ~hit & valid_vec[0];

  always_ff @(posedge clk) begin
    if (take) begin
      fault_r    <= ~hit;
      ev_valid_r <= ev_valid;
      ev_page_r  <= ev_valid ? page_vec[0] : '0;
      total_r    <= fault_cnt_upd;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      frames_r    <= FRAMES_INIT;
      fault_cnt_r <= '0;
    end else begin
      frames_r    <= frames_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fault         = fault_r;
  assign out_ch.evicted_valid = ev_valid_r;
  assign out_ch.evicted_page  = ev_page_r;
  assign out_ch.fault_total   = total_r;

  // a resident page is held by at most one frame
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("more than one frame matched the reference");

  // no more frames are ever occupied than frames_in_use
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) <= 32'(frames_r))
    else $error("more valid frames than frames in use");

  // a hit reports neither a fault nor an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    take && hit |=> out_valid_r && !ev_valid_r && !fault_r)
    else $error("hit result carries a fault or eviction");

  // emptying the frames clears every valid mark and the fault total
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    flush |=> (valid_vec == '0) && (fault_cnt_r == '0))
    else $error("frames not emptied after flush");

endmodule

### bench/testbench.sv
// self-checking bench for the lru page replacement stack unit: directed table, then random
module testbench;
  import lru_pkg::*;

  localparam int SLOTS       = MAX_FRAME_SLOTS_DEF;
  localparam int LONG_HOLD   = 200;   // cycles the result side holds off to back the block up
  localparam int STUCK_LIMIT = 4000;  // cycles with no transfer or register access before giving up
  localparam int SHOWN_MAX   = 40;    // mismatch lines printed, the rest are only counted

  // register map: frames_in_use at index 0, the next index is not decoded
  localparam logic [CFG_ADDR_W-3:0] REG_SPARE   = ~REG_FRAMES;
  localparam logic [CFG_ADDR_W-1:0] ADDR_FRAMES = {REG_FRAMES, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE  = {REG_SPARE, 2'b00};

  typedef struct packed {
    logic               fault;
    logic               ev_valid;
    logic [PAGE_W-1:0]  ev_page;
    logic [FAULT_W-1:0] total;
  } lru_result_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              eor;
    logic              typed;  // want holds a hand-written result
    lru_result_t       want;
  } page_ref_t;

  typedef enum logic [1:0] {ROW_REF, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_ADDR_W-1:0]   addr;
    logic [CFG_DATA_W-1:0]   data;
    page_ref_t               ref_item;
  } plan_row_t;

  localparam lru_result_t NO_WANT = '0;

  // directed table; results typed in where they follow by hand, the rest go to the predictor
  localparam plan_row_t PLAN [23] = '{
    // reset gives four empty frames
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'h0000, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'd1}}},
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'hFFFF, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'd2}}},
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'h0000, 1'b0, 1'b1, '{1'b0, 1'b0, 16'h0000, 32'd2}}},
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'h0001, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'd3}}},
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'h0002, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'd4}}},
    // full: the least recent page goes, not the first one loaded
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'h0003, 1'b0, 1'b1, '{1'b1, 1'b1, 16'hFFFF, 32'd5}}},
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'h0000, 1'b0, 1'b1, '{1'b0, 1'b0, 16'h0000, 32'd5}}},
    // end of run reports the state before the clear
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'h0004, 1'b1, 1'b1, '{1'b1, 1'b1, 16'h0001, 32'd6}}},
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'h0001, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'd1}}},
    // zero frames acts as one
    '{ROW_CFG, ADDR_FRAMES, 32'd0, '{16'h0000, 1'b0, 1'b0, NO_WANT}},
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'h0007, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'd1}}},
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'h0007, 1'b0, 1'b1, '{1'b0, 1'b0, 16'h0000, 32'd1}}},
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'h0008, 1'b0, 1'b1, '{1'b1, 1'b1, 16'h0007, 32'd2}}},
    // undecoded register: nothing changes, page 8 still resident
    '{ROW_CFG, ADDR_SPARE, 32'd16, '{16'h0000, 1'b0, 1'b0, NO_WANT}},
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'h0008, 1'b0, 1'b1, '{1'b0, 1'b0, 16'h0000, 32'd2}}},
    // all ones saturates to the slot count
    '{ROW_CFG, ADDR_FRAMES, 32'hFFFF_FFFF, '{16'h0000, 1'b0, 1'b0, NO_WANT}},
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'h8000, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'd1}}},
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'h5555, 1'b0, 1'b0, NO_WANT}},
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'hAAAA, 1'b0, 1'b0, NO_WANT}},
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'h8000, 1'b0, 1'b0, NO_WANT}},
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'h7FFF, 1'b0, 1'b0, NO_WANT}},
    '{ROW_REF, ADDR_FRAMES, 32'd0, '{16'h5555, 1'b1, 1'b0, NO_WANT}},
    '{ROW_CFG, ADDR_FRAMES, 32'd16, '{16'h0000, 1'b0, 1'b0, NO_WANT}}
  };

  // frame counts for the random phases, extremes and out-of-range values among them
  localparam logic [CFG_FRAMES_W-1:0] FRAME_PICKS [12] = '{
    5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd5, 5'd17, 5'd4, 5'd16, 5'd1, 5'd9, 5'd3
  };
  localparam int TX_IDLE [3] = '{24, 83, 0};
  localparam int RX_IDLE [3] = '{83, 24, 0};

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  lru_req_if in_if ();
  lru_rsp_if out_if ();

  lru_page_replacement_stack_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // recency stack predictor: position 0 least recent, nframes-1 most recent
  // ---------------------------------------------------------------------------
  logic [PAGE_W-1:0]  stack_page [SLOTS];
  bit                 stack_live [SLOTS];
  logic [FAULT_W-1:0] fault_run;
  int unsigned        nframes;

  function automatic int unsigned clamp_frames(logic [CFG_FRAMES_W-1:0] v);
    if (v == '0) return 1;
    if (v > SLOTS) return SLOTS;
    return 32'(v);
  endfunction

  function automatic void empty_frames();
    foreach (stack_live[k]) begin
      stack_live[k] = 1'b0;
      stack_page[k] = '0;
    end
    fault_run = '0;
  endfunction

  function automatic lru_result_t lru_predict(logic [PAGE_W-1:0] pg, logic eor);
    int top;
    int hit_at;
    lru_result_t r;
    top    = nframes - 1;
    hit_at = -1;
    r      = '0;
    for (int k = 0; k < nframes; k++) begin
      if (hit_at < 0 && stack_live[k] && stack_page[k] == pg) hit_at = k;
    end
    if (hit_at >= 0) begin
      // hit: entries above the old position close the gap
      for (int k = hit_at; k < top; k++) begin
        stack_page[k] = stack_page[k+1];
        stack_live[k] = stack_live[k+1];
      end
    end else begin
      // miss: the bottom entry falls out, everything moves down one
      r.fault = 1'b1;
      if (stack_live[0]) begin
        r.ev_valid = 1'b1;
        r.ev_page  = stack_page[0];
      end
      for (int k = 0; k < top; k++) begin
        stack_page[k] = stack_page[k+1];
        stack_live[k] = stack_live[k+1];
      end
      if (fault_run != '1) fault_run = fault_run + FAULT_W'(1);
    end
    stack_page[top] = pg;
    stack_live[top] = 1'b1;
    r.total = fault_run;
    if (eor) empty_frames();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // shared state between stimulus, sender, receiver and watchdog
  // ---------------------------------------------------------------------------
  page_ref_t   ref_q[$];      // references waiting to be offered
  lru_result_t due_q[$];      // results owed by the block, oldest first
  page_ref_t   offered;       // reference currently on the input channel
  bit          offering;      // sender side: an item is being held up
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          holds_asked;   // long hold-offs requested by the stimulus
  int          holds_done;
  int          hold_left;
  int          mismatches;
  int          stuck_cycles;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < SHOWN_MAX)
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // sender: one reference per transfer, the predictor runs on the transferred values
  always @(posedge clk) begin : sender
    lru_result_t got;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        got = lru_predict(in_if.page, in_if.end_of_run);
        due_q.push_back(offered.typed ? offered.want : got);
        offering = 1'b0;
      end
      // valid stays up until the transfer; idle gaps only fall between items
      if (!offering && ref_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        offered  = ref_q.pop_front();
        offering = 1'b1;
        in_if.page       <= offered.page;
        in_if.end_of_run <= offered.eor;
      end
      in_if.valid <= offering;
    end
  end

  // receiver: random stalls plus the occasional long hold-off, checks every transfer
  always @(posedge clk) begin : receiver
    lru_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (due_q.size() == 0) begin
          report_mismatch("result with nothing due, fault_total", out_if.fault_total, 32'd0);
        end else begin
          want = due_q.pop_front();
          if (out_if.fault !== want.fault)
            report_mismatch("fault", 32'(out_if.fault), 32'(want.fault));
          if (out_if.evicted_valid !== want.ev_valid)
            report_mismatch("evicted_valid", 32'(out_if.evicted_valid), 32'(want.ev_valid));
          if (out_if.evicted_page !== want.ev_page)
            report_mismatch("evicted_page", 32'(out_if.evicted_page), 32'(want.ev_page));
          if (out_if.fault_total !== want.total)
            report_mismatch("fault_total", out_if.fault_total, want.total);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = LONG_HOLD;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // watchdog: any transfer or register access counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_psel) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // hold off until every queued reference is transferred and every result is back
  task automatic wait_quiet();
    while (ref_q.size() != 0 || offering || due_q.size() != 0) @(posedge clk);
  endtask

  // setup then access phase; the register takes the value once pready is seen
  task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == ADDR_FRAMES) begin
      nframes = clamp_frames(data[CFG_FRAMES_W-1:0]);
      empty_frames();
    end
  endtask

  // mostly a small hot set just larger than the frames, so hits and evictions both
  // happen; the rest is any 16-bit page
  task automatic queue_refs(int count);
    page_ref_t   item;
    logic [15:0] hot_base;
    hot_base = 16'($urandom);
    for (int i = 0; i < count; i++) begin
      item       = '0;
      item.page  = ($urandom_range(9) < 7) ? hot_base + 16'($urandom_range(nframes + 3))
                                           : 16'($urandom);
      item.eor   = ($urandom_range(49) == 0);
      ref_q.push_back(item);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    logic [31:0] rnd;
    page_ref_t   item;

    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.page       = '0;
    in_if.end_of_run = 1'b0;
    out_if.ready     = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    offering         = 1'b0;
    holds_asked      = 0;
    holds_done       = 0;
    hold_left        = 0;
    mismatches       = 0;
    stuck_cycles     = 0;
    tx_idle_pct      = TX_IDLE[0];
    rx_idle_pct      = RX_IDLE[0];
    nframes          = clamp_frames(CFG_FRAMES_W'(FRAMES_RESET));
    empty_frames();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CFG) begin
        wait_quiet();
        apb_write(PLAN[i].addr, PLAN[i].data);
      end else begin
        item = PLAN[i].ref_item;
        ref_q.push_back(item);
      end
    end

    // random phases: receiver-heavy idling, sender-heavy idling, then full rate
    for (int mode = 0; mode < 3; mode++) begin
      for (int sub = 0; sub < 4; sub++) begin
        wait_quiet();
        tx_idle_pct = TX_IDLE[mode];
        rx_idle_pct = RX_IDLE[mode];
        rnd = $urandom;
        apb_write(ADDR_FRAMES, {rnd[31:CFG_FRAMES_W], FRAME_PICKS[mode * 4 + sub]});
        // back the block up while the sender keeps offering
        if (sub == 0 && mode == 2) holds_asked++;
        queue_refs(33);
        // sender pauses mid-run until the block has drained
        if (sub == 1) wait_quiet();
        queue_refs(33);
      end
    end

    wait_quiet();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### lru_page_replacement_stack_unit.f
rtl/lru_pkg.sv
rtl/lru_if.sv
rtl/lru_cell.sv
rtl/lru_page_replacement_stack_unit.sv
bench/testbench.sv
